/* hw/rtl/sepp_pkg.sv */
// shared constants, types and tables for the semi-elliptic path point block
// no dependencies
package sepp_pkg;

  localparam int unsigned CordicSteps = 18;
  localparam int unsigned TableLen    = 24;
  localparam int unsigned AngW        = 20;
  localparam int unsigned RadW        = 24;
  localparam int unsigned OutW        = 26;
  localparam int unsigned CW          = 34;   // cordic datapath width, Q2.30 plus growth
  localparam int unsigned ZW          = 33;   // phase residue width
  localparam int unsigned Margin      = 66;
  localparam logic [30:0] RadToPhase  = 31'd683565276;
  localparam logic signed [CW-1:0] CordicX0 = 34'sd652032874;
  localparam int unsigned PaddrW      = 5;
  localparam int unsigned QDepth      = 4;

  // register addresses
  localparam logic [PaddrW-1:0] AddrRadiusA  = 5'h00;
  localparam logic [PaddrW-1:0] AddrRadiusB  = 5'h04;
  localparam logic [PaddrW-1:0] AddrStart    = 5'h08;
  localparam logic [PaddrW-1:0] AddrNearSt   = 5'h0c;
  localparam logic [PaddrW-1:0] AddrNearEnd  = 5'h10;
  localparam logic [PaddrW-1:0] AddrCw       = 5'h14;
  localparam logic [PaddrW-1:0] AddrStartHy  = 5'h18;
  localparam logic [PaddrW-1:0] AddrEndHy    = 5'h1c;

  localparam logic [1:0] RegionArc   = 2'd0;
  localparam logic [1:0] RegionStart = 2'd1;
  localparam logic [1:0] RegionEnd   = 2'd2;

  // classified beat handed from front to back
  typedef struct packed {
    logic signed [AngW-1:0] ux;
    logic signed [AngW-1:0] vy;
    logic signed [AngW-1:0] sux;
    logic signed [AngW-1:0] svy;
    logic [1:0]             region;
  } work_t;

  function automatic logic [ZW-1:0] atan_lut(input int unsigned i);
    logic [ZW-1:0] r;
    case (i)
      0: r = 33'd536870912;  1: r = 33'd316933406;  2: r = 33'd167458907;
      3: r = 33'd85004756;   4: r = 33'd42667331;   5: r = 33'd21354465;
      6: r = 33'd10679838;   7: r = 33'd5340245;    8: r = 33'd2670163;
      9: r = 33'd1335087;    10: r = 33'd667544;    11: r = 33'd333772;
      12: r = 33'd166886;    13: r = 33'd83443;     14: r = 33'd41722;
      15: r = 33'd20861;     16: r = 33'd10430;     17: r = 33'd5215;
      18: r = 33'd2608;      19: r = 33'd1304;      20: r = 33'd652;
      21: r = 33'd326;       22: r = 33'd163;       23: r = 33'd81;
      default: r = '0;
    endcase
    return r;
  endfunction

  // region choice and hold rule for one angle
  function automatic logic [2*AngW+1:0] classify(
    input logic signed [AngW-1:0] t, input logic signed [AngW-1:0] ns,
    input logic signed [AngW-1:0] ne, input logic cw, input logic shy,
    input logic ehy);
    logic arc, nearst;
    logic signed [AngW:0] t1, ns1, ne1;
    logic signed [AngW-1:0] u, v;
    logic [1:0] rg;
    t1 = t; ns1 = ns; ne1 = ne;
    if (cw) begin
      arc = (t1 < ns1) && (t1 > ne1);
      nearst = t1 > (ns1 - $signed((AngW+1)'(Margin)));
    end else begin
      arc = (t1 > ns1) && (t1 < ne1);
      nearst = t1 < (ns1 + $signed((AngW+1)'(Margin)));
    end
    u = t; v = t;
    if (arc) begin
      rg = RegionArc;
    end else if (nearst) begin
      rg = RegionStart;
      if (shy) u = ns; else v = ns;
    end else begin
      rg = RegionEnd;
      if (ehy) u = ne; else v = ne;
    end
    return {u, v, rg};
  endfunction

endpackage

/* hw/rtl/semiellipse_path_point.sv */
// top level of the semi-elliptic path point block with its register file
// depends on sepp_pkg, sepp_front, sepp_back
//
// Takes one angle beat per cycle while not full and returns the point on
// the elliptic path, relative to the start point, with its region code.
// Throughput is one beat per cycle unless stalled, set by the fully
// pipelined cordic lanes (four angles in parallel: the point and the start
// point). A four-entry queue between the classifier and the pipeline absorbs
// stalls; the whole back pipeline holds while a result waits unpopped. The
// user must write registers only while the block is idle; it is not enforced.
module semiellipse_path_point #(
  parameter int unsigned CORDIC_STEPS = sepp_pkg::CordicSteps
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic psel,
  input  logic penable,
  input  logic pwrite,
  input  logic [sepp_pkg::PaddrW-1:0] paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic pready,
  input  logic push,
  output logic full,
  input  logic signed [sepp_pkg::AngW-1:0] angle_i,
  output logic empty,
  input  logic pop,
  output logic signed [sepp_pkg::OutW-1:0] dx_o,
  output logic signed [sepp_pkg::OutW-1:0] dy_o,
  output logic [1:0] region_o
);
  logic [23:0] ra_q, rb_q;
  logic signed [19:0] st_q, ns_q, ne_q;
  logic cw_q, shy_q, ehy_q;
  logic qv, qp;
  sepp_pkg::work_t qd;
  logic wr;

  assign pready = 1'b1;
  assign wr = psel && penable && pwrite;

  // register writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ra_q <= '0; rb_q <= '0; st_q <= '0; ns_q <= '0; ne_q <= '0;
      cw_q <= 1'b0; shy_q <= 1'b0; ehy_q <= 1'b0;
    end else if (wr) begin
      case (paddr)
        sepp_pkg::AddrRadiusA: ra_q <= pwdata[23:0];
        sepp_pkg::AddrRadiusB: rb_q <= pwdata[23:0];
        sepp_pkg::AddrStart:   st_q <= pwdata[19:0];
        sepp_pkg::AddrNearSt:  ns_q <= pwdata[19:0];
        sepp_pkg::AddrNearEnd: ne_q <= pwdata[19:0];
        sepp_pkg::AddrCw:      cw_q <= pwdata[0];
        sepp_pkg::AddrStartHy: shy_q <= pwdata[0];
        sepp_pkg::AddrEndHy:   ehy_q <= pwdata[0];
        default: ;
      endcase
    end
  end

  // register reads
  always_comb begin
    case (paddr)
      sepp_pkg::AddrRadiusA: prdata = {8'd0, ra_q};
      sepp_pkg::AddrRadiusB: prdata = {8'd0, rb_q};
      sepp_pkg::AddrStart:   prdata = {12'd0, st_q};
      sepp_pkg::AddrNearSt:  prdata = {12'd0, ns_q};
      sepp_pkg::AddrNearEnd: prdata = {12'd0, ne_q};
      sepp_pkg::AddrCw:      prdata = {31'd0, cw_q};
      sepp_pkg::AddrStartHy: prdata = {31'd0, shy_q};
      sepp_pkg::AddrEndHy:   prdata = {31'd0, ehy_q};
      default:               prdata = '0;
    endcase
  end

  sepp_front u_front (
    .clk_i, .rst_ni, .push_i(push), .full_o(full), .angle_i,
    .start_angle_i(st_q), .near_start_angle_i(ns_q), .near_end_angle_i(ne_q),
    .clockwise_i(cw_q), .start_hold_y_i(shy_q), .end_hold_y_i(ehy_q),
    .q_valid_o(qv), .q_pop_i(qp), .q_data_o(qd)
  );

  sepp_back #(.CORDIC_STEPS(CORDIC_STEPS)) u_back (
    .clk_i, .rst_ni, .q_valid_i(qv), .q_pop_o(qp), .q_data_i(qd),
    .radius_a_i(ra_q), .radius_b_i(rb_q), .empty_o(empty), .pop_i(pop),
    .dx_o, .dy_o, .region_o
  );
endmodule

/* hw/rtl/sepp_front.sv */
// front end: takes input beats, classifies region, picks cordic angles
// depends on sepp_pkg
module sepp_front (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          push_i,
  output logic                          full_o,
  input  logic signed [sepp_pkg::AngW-1:0] angle_i,
  input  logic signed [sepp_pkg::AngW-1:0] start_angle_i,
  input  logic signed [sepp_pkg::AngW-1:0] near_start_angle_i,
  input  logic signed [sepp_pkg::AngW-1:0] near_end_angle_i,
  input  logic                          clockwise_i,
  input  logic                          start_hold_y_i,
  input  logic                          end_hold_y_i,
  output logic                          q_valid_o,
  input  logic                          q_pop_i,
  output sepp_pkg::work_t               q_data_o
);
  localparam int unsigned PW = $clog2(sepp_pkg::QDepth);

  sepp_pkg::work_t mem_q [sepp_pkg::QDepth];
  logic [PW-1:0] wr_q, rd_q;
  logic [PW:0]   cnt_q;
  logic [2*sepp_pkg::AngW+1:0] ci, cs;
  sepp_pkg::work_t w;
  logic do_push, do_pop;

  assign full_o    = (cnt_q == (PW+1)'(sepp_pkg::QDepth));
  assign q_valid_o = (cnt_q != '0);
  assign do_push   = push_i && !full_o;
  assign do_pop    = q_pop_i && q_valid_o;
  assign q_data_o  = mem_q[rd_q];

  // classify the beat and the start point
  always_comb begin
    ci = sepp_pkg::classify(angle_i, near_start_angle_i, near_end_angle_i,
                            clockwise_i, start_hold_y_i, end_hold_y_i);
    cs = sepp_pkg::classify(start_angle_i, near_start_angle_i, near_end_angle_i,
                            clockwise_i, start_hold_y_i, end_hold_y_i);
    w.ux     = ci[2*sepp_pkg::AngW+1:sepp_pkg::AngW+2];
    w.vy     = ci[sepp_pkg::AngW+1:2];
    w.region = ci[1:0];
    w.sux    = cs[2*sepp_pkg::AngW+1:sepp_pkg::AngW+2];
    w.svy    = cs[sepp_pkg::AngW+1:2];
  end

  // queue storage
  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_q] <= w;
  end

  // queue pointers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q <= '0; rd_q <= '0; cnt_q <= '0;
    end else begin
      if (do_push) wr_q <= wr_q + 1'b1;
      if (do_pop) rd_q <= rd_q + 1'b1;
      cnt_q <= cnt_q + (PW+1)'(do_push) - (PW+1)'(do_pop);
    end
  end
endmodule

/* hw/rtl/sepp_cordic.sv */
// pipelined rotation cordic for four angles in parallel lanes
// depends on sepp_pkg
module sepp_cordic #(
  parameter int unsigned CORDIC_STEPS = sepp_pkg::CordicSteps
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          en_i,
  input  logic                          valid_i,
  input  logic signed [sepp_pkg::AngW-1:0] ang_i [4],
  input  logic [1:0]                    region_i,
  output logic                          valid_o,
  output logic signed [sepp_pkg::CW-1:0] cos_o [4],
  output logic signed [sepp_pkg::CW-1:0] sin_o [4],
  output logic [1:0]                    region_o
);
  localparam int unsigned CW = sepp_pkg::CW;
  localparam int unsigned ZW = sepp_pkg::ZW;
  localparam int unsigned NS = CORDIC_STEPS;

  logic signed [CW-1:0] x_q [NS+1][4];
  logic signed [CW-1:0] y_q [NS+1][4];
  logic signed [ZW-1:0] z_q [NS+1][4];
  logic                 f_q [NS+1][4];
  logic [1:0]           r_q [NS+1];
  logic                 v_q [NS+1];
  logic signed [CW-1:0] cx_q [4];
  logic signed [CW-1:0] cy_q [4];
  logic [1:0]           cr_q;
  logic                 cv_q;
  logic signed [51:0]   prod [4];
  logic [31:0]          ph [4];
  logic [31:0]          phf [4];
  logic                 flp [4];

  // angle to phase, fold into the right half plane
  always_comb begin
    for (int l = 0; l < 4; l++) begin
      prod[l] = 52'(ang_i[l]) * $signed({21'd0, sepp_pkg::RadToPhase});
      ph[l] = 32'((prod[l] + 52'sd32768) >>> 16);
      flp[l] = ph[l][31] ^ ph[l][30];
      phf[l] = flp[l] ? (ph[l] - 32'h8000_0000) : ph[l];
    end
  end

  // stage zero registers the folded phase
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int l = 0; l < 4; l++) begin
        x_q[0][l] <= sepp_pkg::CordicX0;
        y_q[0][l] <= '0;
        z_q[0][l] <= ZW'($signed(phf[l]));
        f_q[0][l] <= flp[l];
      end
      r_q[0] <= region_i;
    end
  end

  // one micro-rotation per stage
  for (genvar s = 0; s < NS; s++) begin : g_stage
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        for (int l = 0; l < 4; l++) begin
          if (!z_q[s][l][ZW-1]) begin
            x_q[s+1][l] <= x_q[s][l] - (y_q[s][l] >>> s);
            y_q[s+1][l] <= y_q[s][l] + (x_q[s][l] >>> s);
            z_q[s+1][l] <= z_q[s][l] - $signed(sepp_pkg::atan_lut(s));
          end else begin
            x_q[s+1][l] <= x_q[s][l] + (y_q[s][l] >>> s);
            y_q[s+1][l] <= y_q[s][l] - (x_q[s][l] >>> s);
            z_q[s+1][l] <= z_q[s][l] + $signed(sepp_pkg::atan_lut(s));
          end
          f_q[s+1][l] <= f_q[s][l];
        end
        r_q[s+1] <= r_q[s];
      end
    end
  end

  // undo the fold
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int l = 0; l < 4; l++) begin
        cx_q[l] <= f_q[NS][l] ? -x_q[NS][l] : x_q[NS][l];
        cy_q[l] <= f_q[NS][l] ? -y_q[NS][l] : y_q[NS][l];
      end
      cr_q <= r_q[NS];
    end
  end

  // valid pipeline
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int s = 0; s <= NS; s++) v_q[s] <= 1'b0;
      cv_q <= 1'b0;
    end else if (en_i) begin
      v_q[0] <= valid_i;
      for (int s = 0; s < NS; s++) v_q[s+1] <= v_q[s];
      cv_q <= v_q[NS];
    end
  end

  assign valid_o  = cv_q;
  assign cos_o    = cx_q;
  assign sin_o    = cy_q;
  assign region_o = cr_q;
endmodule

/* hw/rtl/sepp_back.sv */
// back end: cordic, radius scaling, start offset, saturation, output register
// depends on sepp_pkg and sepp_cordic
module sepp_back #(
  parameter int unsigned CORDIC_STEPS = sepp_pkg::CordicSteps
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          q_valid_i,
  output logic                          q_pop_o,
  input  sepp_pkg::work_t               q_data_i,
  input  logic [sepp_pkg::RadW-1:0]     radius_a_i,
  input  logic [sepp_pkg::RadW-1:0]     radius_b_i,
  output logic                          empty_o,
  input  logic                          pop_i,
  output logic signed [sepp_pkg::OutW-1:0] dx_o,
  output logic signed [sepp_pkg::OutW-1:0] dy_o,
  output logic [1:0]                    region_o
);
  localparam int unsigned CW = sepp_pkg::CW;
  localparam int unsigned OutW = sepp_pkg::OutW;
  localparam int unsigned PW = CW + sepp_pkg::RadW + 1;

  logic en;
  logic cv;
  logic signed [sepp_pkg::AngW-1:0] ang [4];
  logic signed [CW-1:0] cc [4];
  logic signed [CW-1:0] ss [4];
  logic [1:0] cr;
  logic signed [PW-1:0] p_q [4];
  logic [1:0] pr_q;
  logic pv_q;
  logic signed [PW-30:0] c_s [4];
  logic signed [PW-29:0] ddx, ddy;
  logic signed [OutW-1:0] dx_q, dy_q;
  logic [1:0] rg_q;
  logic ov_q;

  // whole pipeline advances unless output holds an untaken beat
  assign en = !ov_q || pop_i;
  assign q_pop_o = en;
  assign ang[0] = q_data_i.ux;
  assign ang[1] = q_data_i.vy;
  assign ang[2] = q_data_i.sux;
  assign ang[3] = q_data_i.svy;

  sepp_cordic #(.CORDIC_STEPS(CORDIC_STEPS)) u_cordic (
    .clk_i, .rst_ni, .en_i(en), .valid_i(q_valid_i), .ang_i(ang),
    .region_i(q_data_i.region), .valid_o(cv), .cos_o(cc), .sin_o(ss),
    .region_o(cr)
  );

  // radius products
  always_ff @(posedge clk_i) begin
    if (en) begin
      p_q[0] <= $signed({1'b0, radius_a_i}) * cc[0];
      p_q[1] <= $signed({1'b0, radius_b_i}) * ss[1];
      p_q[2] <= $signed({1'b0, radius_a_i}) * cc[2];
      p_q[3] <= $signed({1'b0, radius_b_i}) * ss[3];
      pr_q <= cr;
    end
  end

  // round, subtract start point, saturate
  always_comb begin
    for (int l = 0; l < 4; l++)
      c_s[l] = (PW-29)'((p_q[l] + PW'(64'sd536870912)) >>> 30);
    ddx = (PW-28)'(c_s[0]) - (PW-28)'(c_s[2]);
    ddy = (PW-28)'(c_s[1]) - (PW-28)'(c_s[3]);
  end

  function automatic logic signed [OutW-1:0] sat(input logic signed [PW-29:0] v);
    logic signed [PW-29:0] mx, mn;
    mx = (PW-28)'(33554431);
    mn = -(PW-28)'(33554432);
    if (v > mx) return OutW'(mx);
    if (v < mn) return OutW'(mn);
    return OutW'(v);
  endfunction

  always_ff @(posedge clk_i) begin
    if (en) begin
      dx_q <= sat(ddx);
      dy_q <= sat(ddy);
      rg_q <= pr_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pv_q <= 1'b0;
      ov_q <= 1'b0;
    end else if (en) begin
      pv_q <= cv;
      ov_q <= pv_q;
    end
  end

  assign empty_o  = !ov_q;
  assign dx_o     = dx_q;
  assign dy_o     = dy_q;
  assign region_o = rg_q;
endmodule
